[rtl/cdfe_pkg.sv]
// Shared types, constants and the month length table of the clock field editor.
package cdfe_pkg;

    // Key press codes.
    localparam logic [2:0] ACT_LOAD   = 3'd0;
    localparam logic [2:0] ACT_LEFT   = 3'd1;
    localparam logic [2:0] ACT_RIGHT  = 3'd2;
    localparam logic [2:0] ACT_UP     = 3'd3;
    localparam logic [2:0] ACT_DOWN   = 3'd4;
    localparam logic [2:0] ACT_TOGGLE = 3'd5;
    localparam logic [2:0] ACT_COMMIT = 3'd6;

    // Cursor positions.
    localparam logic [2:0] FIELD_YEAR   = 3'd0;
    localparam logic [2:0] FIELD_MONTH  = 3'd1;
    localparam logic [2:0] FIELD_DAY    = 3'd2;
    localparam logic [2:0] FIELD_HOUR   = 3'd3;
    localparam logic [2:0] FIELD_MINUTE = 3'd4;

    localparam logic [2:0] CURSOR_MAX    = FIELD_MINUTE;
    localparam logic [9:0] YEAR_MAX      = 10'd1023;
    localparam logic [3:0] MONTH_IDX_MAX = 4'd11;
    localparam logic [3:0] MONTHS        = 4'd12;
    localparam logic [4:0] HOUR_MAX      = 5'd23;
    localparam logic [5:0] MINUTE_MAX    = 6'd59;
    localparam logic [4:0] HALF_DAY      = 5'd12;

    typedef struct packed {
        logic [2:0] action;
        logic [9:0] load_year;
        logic [3:0] load_month;
        logic [4:0] load_day;
        logic [4:0] load_hour;
        logic [5:0] load_minute;
    } item_t;

    typedef struct packed {
        logic [2:0] cursor;
        logic [9:0] year;
        logic [3:0] month_idx;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic       twelve;
    } state_t;

    typedef struct packed {
        logic [2:0] cursor;
        logic [9:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic       twelve_hour_mode;
        logic [4:0] display_hour;
        logic       is_pm;
        logic       commit;
    } result_t;

    // Days in a month, indexed from January as 0. February never has a leap day.
    function automatic logic [4:0] month_len(input logic [3:0] idx);
        logic [4:0] len;
        unique case (idx)
            4'd1:                      len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

[rtl/cdfe_next_state.sv]
// Applies one key press to the editor state and normalizes the fields.
module cdfe_next_state
    import cdfe_pkg::*;
(
    input  state_t cur,
    input  item_t  item,
    output state_t nxt,
    output logic   commit
);

    logic [3:0] mon_c;
    logic [5:0] day_c;
    logic [4:0] hour_c;
    logic [5:0] min_c;
    logic [9:0] year_c;
    logic [4:0] len;
    logic       step_up;
    logic       step_dn;

    always_comb begin
        nxt     = cur;
        commit  = 1'b0;
        mon_c   = cur.month_idx;
        day_c   = {1'b0, cur.day};
        hour_c  = cur.hour;
        min_c   = cur.minute;
        year_c  = cur.year;
        step_up = 1'b0;
        step_dn = 1'b0;

        unique case (item.action)
            ACT_LOAD: begin
                year_c = item.load_year;
                if (item.load_month == 4'd0) begin
                    mon_c = MONTH_IDX_MAX;
                end else if (item.load_month > MONTHS) begin
                    mon_c = 4'd0;
                end else begin
                    mon_c = item.load_month - 4'd1;
                end
                day_c  = {1'b0, item.load_day};
                hour_c = (item.load_hour > HOUR_MAX) ? 5'd0 : item.load_hour;
                min_c  = (item.load_minute > MINUTE_MAX) ? 6'd0 : item.load_minute;
            end
            ACT_LEFT: begin
                if (cur.cursor != FIELD_YEAR) nxt.cursor = cur.cursor - 3'd1;
            end
            ACT_RIGHT: begin
                if (cur.cursor < CURSOR_MAX) nxt.cursor = cur.cursor + 3'd1;
            end
            ACT_UP:     step_up = 1'b1;
            ACT_DOWN:   step_dn = 1'b1;
            ACT_TOGGLE: nxt.twelve = ~cur.twelve;
            ACT_COMMIT: commit = 1'b1;
            default: ;
        endcase

        if (step_up || step_dn) begin
            unique case (cur.cursor)
                FIELD_YEAR: begin
                    if (step_up && cur.year != YEAR_MAX) year_c = cur.year + 10'd1;
                    if (step_dn && cur.year != 10'd0)    year_c = cur.year - 10'd1;
                end
                FIELD_MONTH: begin
                    if (step_up) begin
                        mon_c = (cur.month_idx == MONTH_IDX_MAX) ? 4'd0 : cur.month_idx + 4'd1;
                    end else begin
                        mon_c = (cur.month_idx == 4'd0) ? MONTH_IDX_MAX : cur.month_idx - 4'd1;
                    end
                end
                FIELD_DAY: begin
                    day_c = step_up ? ({1'b0, cur.day} + 6'd1) : ({1'b0, cur.day} - 6'd1);
                end
                FIELD_HOUR: begin
                    if (step_up) begin
                        hour_c = (cur.hour >= HOUR_MAX) ? 5'd0 : cur.hour + 5'd1;
                    end else begin
                        hour_c = (cur.hour == 5'd0) ? HOUR_MAX : cur.hour - 5'd1;
                    end
                end
                default: begin
                    if (step_up) begin
                        min_c = (cur.minute >= MINUTE_MAX) ? 6'd0 : cur.minute + 6'd1;
                    end else begin
                        min_c = (cur.minute == 6'd0) ? MINUTE_MAX : cur.minute - 6'd1;
                    end
                end
            endcase
        end

        // A day of zero rolls back to the month's last day; past the end it wraps to 1.
        len = month_len(mon_c);
        if (day_c == 6'd0) begin
            nxt.day = len;
        end else if (day_c > {1'b0, len}) begin
            nxt.day = 5'd1;
        end else begin
            nxt.day = day_c[4:0];
        end

        nxt.year      = year_c;
        nxt.month_idx = mon_c;
        nxt.hour      = hour_c;
        nxt.minute    = min_c;
    end

endmodule

[rtl/cdfe_result_fmt.sv]
// Builds the result word: calendar month, display hour (12-hour form in 12-hour mode) and PM flag.
module cdfe_result_fmt
    import cdfe_pkg::*;
(
    input  state_t  st,
    input  logic    commit,
    output result_t res
);

    logic       pm;
    logic [4:0] h12;

    assign pm  = (st.hour >= HALF_DAY);
    assign h12 = pm ? (st.hour - HALF_DAY) : st.hour;

    always_comb begin
        res.cursor           = st.cursor;
        res.year             = st.year;
        res.month            = st.month_idx + 4'd1;
        res.day              = st.day;
        res.hour             = st.hour;
        res.minute           = st.minute;
        res.twelve_hour_mode = st.twelve;
        res.is_pm            = pm;
        res.commit           = commit;
        if (st.twelve) begin
            res.display_hour = (h12 == 5'd0) ? HALF_DAY : h12;
        end else begin
            res.display_hour = st.hour;
        end
    end

endmodule

[rtl/clock_date_field_editor_unit.sv]
// Top level of the clock date and time field editor.
// A word accepted into the input register moves on to the result register and shows on
// m_tvalid. Throughput: one word per cycle while m_tready stays high; the edit and normalize
// logic sits between the input register and the result register, and the state register
// updates in the same cycle. Reset (aresetn low, synchronous) empties both registers and
// sets cursor 0, year 0, January 1, 00:00 and 24-hour display.
module clock_date_field_editor_unit
    import cdfe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // load_year[9:0], load_month[13:10], load_day[18:14], load_hour[23:19],
    // load_minute[29:24], zero fill [31:30]
    input  logic [31:0] s_tdata,
    // action[2:0]
    input  logic [2:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // cursor[2:0], year[12:3], month[16:13], day[21:17], hour[26:22], minute[32:27],
    // twelve_hour_mode[33], display_hour[38:34], is_pm[39]
    output logic [39:0] m_tdata,
    // commit
    output logic        m_tuser
);

    // The input register holds one key press word; the result register holds one
    // result word. The press in the input register moves on whenever the result
    // register is empty or is being emptied in the same cycle.
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    state_t  state_reg;
    state_t  state_next;
    logic    commit_next;
    result_t res_next;
    logic    advance;
    logic    s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.action      <= s_tuser;
            in_item_reg.load_year   <= s_tdata[9:0];
            in_item_reg.load_month  <= s_tdata[13:10];
            in_item_reg.load_day    <= s_tdata[18:14];
            in_item_reg.load_hour   <= s_tdata[23:19];
            in_item_reg.load_minute <= s_tdata[29:24];
        end
    end

    // Next state for the press waiting in the input register.
    cdfe_next_state u_next (
        .cur    (state_reg),
        .item   (in_item_reg),
        .nxt    (state_next),
        .commit (commit_next)
    );

    // The result word reflects the state after the press.
    cdfe_result_fmt u_fmt (
        .st     (state_next),
        .commit (commit_next),
        .res    (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.cursor    <= FIELD_YEAR;
            state_reg.year      <= 10'd0;
            state_reg.month_idx <= 4'd0;
            state_reg.day       <= 5'd1;
            state_reg.hour      <= 5'd0;
            state_reg.minute    <= 6'd0;
            state_reg.twelve    <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.commit;
    assign m_tdata  = {out_res_reg.is_pm, out_res_reg.display_hour,
                       out_res_reg.twelve_hour_mode, out_res_reg.minute,
                       out_res_reg.hour, out_res_reg.day, out_res_reg.month,
                       out_res_reg.year, out_res_reg.cursor};

    // The cursor never leaves the five fields.
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.cursor <= CURSOR_MAX)
        else $error("cursor outside field range");

    // Stored date is always normalized to the month table.
    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.month_idx <= MONTH_IDX_MAX && state_reg.day != 5'd0 &&
        state_reg.day <= month_len(state_reg.month_idx))
        else $error("stored date not normalized");

    // Stored time of day is always in range.
    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.hour <= HOUR_MAX && state_reg.minute <= MINUTE_MAX)
        else $error("stored time not normalized");

    // A commit press leaves the edited state untouched and raises the commit flag.
    a_commit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_item_reg.action == ACT_COMMIT |=> $stable(state_reg) && m_tuser)
        else $error("commit press changed state");

endmodule
